// ----- src/pts_pkg.sv -----
// Shared types and constants for the process table scheduler.
// Used by the controller, the datapath and the top level.
`default_nettype none

package pts_pkg;

  // Default number of task slots.
  localparam int SLOT_COUNT_DEF = 16;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_SPAWN    = 3'd0,
    REQ_WAIT     = 3'd1,
    REQ_KILL     = 3'd2,
    REQ_EXIT     = 3'd3,
    REQ_WAKE     = 3'd4,
    REQ_DISPATCH = 3'd5,
    REQ_REPORT   = 3'd6
  } req_t;

  // Slot states.
  typedef enum logic [2:0] {
    SLOT_UNUSED  = 3'd0,
    SLOT_READY   = 3'd1,
    SLOT_RUNNING = 3'd2,
    SLOT_BLOCKED = 3'd3,
    SLOT_ZOMBIE  = 3'd4
  } slot_state_t;

  // Block reasons.
  typedef enum logic [1:0] {
    RSN_NONE = 2'd0,
    RSN_IPC  = 2'd1,
    RSN_WAIT = 2'd2
  } reason_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_PENDING    = 2'd1,
    ST_ERROR      = 2'd2,
    ST_NONE_READY = 2'd3
  } status_t;

  // Run outcome codes.
  typedef enum logic [1:0] {
    RUN_EXITED  = 2'd0,
    RUN_BLOCKED = 2'd1,
    RUN_YIELDED = 2'd2,
    RUN_OTHER   = 2'd3
  } outcome_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_MATCH = 2'd1,
    FSM_PICK  = 2'd2,
    FSM_EXEC  = 2'd3
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic pick;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/process_table_round_robin_scheduler.sv -----
// Top level of the round-robin process table scheduler.
// Instantiates pts_ctrl and pts_dp; depends on pts_pkg.
`default_nettype none

// Each request passes through the sequencer steps in order: accept it and
// latch the request, compare every slot against the request keys in
// parallel, run the priority and round-robin pickers, and update the table
// and load the result register. The block takes no new request until the
// last one is through; the result register lets the next request start while the last
// result beat still waits. Of the table, only the slot states are cleared by reset,
// and the block takes requests as soon as reset is released.
module process_table_round_robin_scheduler
  import pts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] parent_id,
  input  wire logic        use_current_parent,
  input  wire logic [31:0] caller_id,
  input  wire logic [31:0] target_id,
  input  wire logic [31:0] space_id,
  input  wire logic signed [31:0] exit_code,
  input  wire logic [1:0]  run_outcome,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      result_pid,
  output logic [31:0]      result_space,
  output logic signed [31:0] result_exit,
  output logic [4:0]       woken_count,
  output logic             more_work
);

  cmd_t cmd;
  sts_t sts;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pts_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .req_type           (req_type),
    .parent_id          (parent_id),
    .use_current_parent (use_current_parent),
    .caller_id          (caller_id),
    .target_id          (target_id),
    .space_id           (space_id),
    .exit_code          (exit_code),
    .run_outcome        (run_outcome),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .result_pid         (result_pid),
    .result_space       (result_space),
    .result_exit        (result_exit),
    .woken_count        (woken_count),
    .more_work          (more_work)
  );

`ifndef NO_ASSERTIONS
  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in progress");

  // A fresh result beat appears only after an accepted request beat.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
    else $error("result beat without a matching request");

  // An error result carries no pid.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_ERROR)) |-> (result_pid == 32'd0))
    else $error("error result carries a pid");
`endif

endmodule

`default_nettype wire

// ----- src/pts_ctrl.sv -----
// Sequencer of the process table scheduler: load, match, pick, execute.
// Depends on pts_pkg.
`default_nettype none

module pts_ctrl
  import pts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  fsm_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = FSM_MATCH;
        end
      end
      FSM_MATCH: begin
        cmd.match  = 1'b1;
        state_next = FSM_PICK;
      end
      FSM_PICK: begin
        cmd.pick   = 1'b1;
        state_next = FSM_EXEC;
      end
      FSM_EXEC: begin
        // Wait here until the output register can take the result.
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/pts_dp.sv -----
// Datapath of the process table scheduler: slot table, compare vectors,
// priority pickers, update logic and the result register. Depends on pts_pkg.
`default_nettype none

module pts_dp
  import pts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] parent_id,
  input  wire logic        use_current_parent,
  input  wire logic [31:0] caller_id,
  input  wire logic [31:0] target_id,
  input  wire logic [31:0] space_id,
  input  wire logic signed [31:0] exit_code,
  input  wire logic [1:0]  run_outcome,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      result_pid,
  output logic [31:0]      result_space,
  output logic signed [31:0] result_exit,
  output logic [4:0]       woken_count,
  output logic             more_work
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  // Slot table.
  slot_state_t       tbl_state [SLOT_COUNT];
  reason_t           tbl_reason[SLOT_COUNT];
  logic [31:0]       tbl_pid   [SLOT_COUNT];
  logic [31:0]       tbl_parent[SLOT_COUNT];
  logic [31:0]       tbl_space [SLOT_COUNT];
  logic [31:0]       tbl_wait  [SLOT_COUNT];
  logic signed [31:0] tbl_exit [SLOT_COUNT];

  slot_state_t       state_next [SLOT_COUNT];
  reason_t           reason_next[SLOT_COUNT];
  logic [31:0]       pid_next   [SLOT_COUNT];
  logic [31:0]       parent_next[SLOT_COUNT];
  logic [31:0]       space_next [SLOT_COUNT];
  logic [31:0]       wait_next  [SLOT_COUNT];
  logic signed [31:0] exit_next [SLOT_COUNT];

  // Scheduler registers.
  logic [31:0]   next_pid;
  logic [IW-1:0] rr_index;
  logic [31:0]   running_pid;
  logic [IW-1:0] running_slot;

  // Latched request.
  req_t        q_req;
  logic [31:0] q_parent;
  logic        q_use_cur;
  logic [31:0] q_caller;
  logic [31:0] q_target;
  logic [31:0] q_space;
  logic signed [31:0] q_code;
  outcome_t    q_outcome;

  // Compare vectors.
  logic [SLOT_COUNT-1:0] m_free, m_caller, m_target, m_ready, m_wake, m_waiter;

  // Picked indices.
  logic [IW-1:0] p_cidx, p_tidx, p_fidx, p_ridx;
  logic          p_cfound, p_tfound, p_ffound, p_rfound;
  logic [CW-1:0] p_woken;

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_req     <= req_t'(req_type);
      q_parent  <= parent_id;
      q_use_cur <= use_current_parent;
      q_caller  <= caller_id;
      q_target  <= target_id;
      q_space   <= space_id;
      q_code    <= exit_code;
      q_outcome <= outcome_t'(run_outcome);
    end
  end

  // Parallel compare of every slot against the request keys.
  logic [31:0] zkey;
  assign zkey = (q_req == REQ_REPORT) ? tbl_pid[running_slot] : q_target;

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        m_free[i]   <= (tbl_state[i] == SLOT_UNUSED);
        m_caller[i] <= (tbl_state[i] != SLOT_UNUSED) && (q_caller != 32'd0) &&
                       (tbl_pid[i] == q_caller);
        m_target[i] <= (tbl_state[i] != SLOT_UNUSED) && (q_target != 32'd0) &&
                       (tbl_pid[i] == q_target);
        m_ready[i]  <= (tbl_state[i] == SLOT_READY);
        m_wake[i]   <= (q_space != 32'd0) && (tbl_space[i] == q_space) &&
                       (tbl_state[i] == SLOT_BLOCKED) && (tbl_reason[i] == RSN_IPC);
        m_waiter[i] <= (zkey != 32'd0) && (tbl_state[i] == SLOT_BLOCKED) &&
                       (tbl_reason[i] == RSN_WAIT) && (tbl_wait[i] == zkey);
      end
    end
  end

  // Lowest-index pickers, round-robin pick and wake count.
  logic [IW-1:0] c_idx, t_idx, f_idx, r_idx;
  logic          r_found;
  logic [CW-1:0] w_cnt;

  always_comb begin
    logic [SLOT_COUNT-1:0] hi;
    logic [IW-1:0]         lo_idx, hi_idx;
    c_idx  = '0;
    t_idx  = '0;
    f_idx  = '0;
    lo_idx = '0;
    hi_idx = '0;
    w_cnt  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hi[i] = m_ready[i] && (IW'(i) >= rr_index);
    end
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (m_caller[i]) c_idx = IW'(i);
      if (m_target[i]) t_idx = IW'(i);
      if (m_free[i])   f_idx = IW'(i);
      if (m_ready[i])  lo_idx = IW'(i);
      if (hi[i])       hi_idx = IW'(i);
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      w_cnt = w_cnt + CW'(m_wake[i]);
    end
    r_idx   = (|hi) ? hi_idx : lo_idx;
    r_found = |m_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      p_cidx   <= c_idx;
      p_tidx   <= t_idx;
      p_fidx   <= f_idx;
      p_ridx   <= r_idx;
      p_cfound <= |m_caller;
      p_tfound <= |m_target;
      p_ffound <= |m_free;
      p_rfound <= r_found;
      p_woken  <= w_cnt;
    end
  end

  // Request checks on the picked slots.
  logic [31:0]  t_par;
  slot_state_t  t_st;
  logic         wait_ok, kill_ok, kill_do, disp_ok, rep_ok, rep_exit;
  logic [IW-1:0] z_slot;
  logic [SLOT_COUNT-1:0] wake_mask;

  assign t_par    = tbl_parent[p_tidx];
  assign t_st     = tbl_state[p_tidx];
  assign wait_ok  = p_cfound && (q_target != 32'd0) && (q_caller != q_target) &&
                    p_tfound && (t_par == q_caller);
  assign kill_ok  = p_tfound && (q_target != running_pid) &&
                    !((running_pid != 32'd0) && (t_par != running_pid));
  assign kill_do  = kill_ok && (t_st != SLOT_ZOMBIE);
  assign disp_ok  = (running_pid == 32'd0);
  assign rep_ok   = (running_pid != 32'd0);
  assign rep_exit = rep_ok && (q_outcome == RUN_EXITED);
  assign z_slot   = (q_req == REQ_REPORT) ? running_slot : p_tidx;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      wake_mask[i] = m_waiter[i] && (IW'(i) != z_slot);
    end
  end

  // Next contents of every slot.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      state_next[i]  = tbl_state[i];
      reason_next[i] = tbl_reason[i];
      pid_next[i]    = tbl_pid[i];
      parent_next[i] = tbl_parent[i];
      space_next[i]  = tbl_space[i];
      wait_next[i]   = tbl_wait[i];
      exit_next[i]   = tbl_exit[i];
      if (cmd.exec) begin
        unique case (q_req)
          REQ_SPAWN: begin
            if (p_ffound && (IW'(i) == p_fidx)) begin
              state_next[i]  = SLOT_READY;
              reason_next[i] = RSN_NONE;
              pid_next[i]    = next_pid;
              parent_next[i] = q_use_cur ? running_pid : q_parent;
              space_next[i]  = q_space;
              wait_next[i]   = '0;
              exit_next[i]   = '0;
            end
          end
          REQ_WAIT: begin
            if (wait_ok) begin
              if (t_st == SLOT_ZOMBIE) begin
                if (IW'(i) == p_tidx) begin
                  state_next[i]  = SLOT_UNUSED;
                  reason_next[i] = RSN_NONE;
                  pid_next[i]    = '0;
                  parent_next[i] = '0;
                  space_next[i]  = '0;
                  wait_next[i]   = '0;
                  exit_next[i]   = '0;
                end
                if (IW'(i) == p_cidx) begin
                  reason_next[i] = RSN_NONE;
                  wait_next[i]   = '0;
                end
              end else if (IW'(i) == p_cidx) begin
                reason_next[i] = RSN_WAIT;
                wait_next[i]   = q_target;
              end
            end
          end
          REQ_KILL: begin
            if (kill_do) begin
              if (IW'(i) == p_tidx) begin
                exit_next[i]   = q_code;
                reason_next[i] = RSN_NONE;
                wait_next[i]   = '0;
                state_next[i]  = SLOT_ZOMBIE;
              end else if (wake_mask[i]) begin
                reason_next[i] = RSN_NONE;
                wait_next[i]   = '0;
                state_next[i]  = SLOT_READY;
              end
            end
          end
          REQ_WAKE: begin
            if (m_wake[i]) begin
              reason_next[i] = RSN_NONE;
              state_next[i]  = SLOT_READY;
            end
          end
          REQ_DISPATCH: begin
            if (disp_ok && p_rfound && (IW'(i) == p_ridx)) begin
              state_next[i] = SLOT_RUNNING;
            end
          end
          REQ_REPORT: begin
            if (rep_ok && (IW'(i) == running_slot)) begin
              unique case (q_outcome)
                RUN_EXITED: begin
                  reason_next[i] = RSN_NONE;
                  wait_next[i]   = '0;
                  state_next[i]  = SLOT_ZOMBIE;
                end
                RUN_BLOCKED: begin
                  state_next[i] = SLOT_BLOCKED;
                  if (tbl_reason[i] == RSN_NONE) begin
                    reason_next[i] = RSN_IPC;
                  end
                end
                default: begin
                  state_next[i]  = SLOT_READY;
                  reason_next[i] = RSN_NONE;
                  wait_next[i]   = '0;
                end
              endcase
            end else if (rep_exit && wake_mask[i]) begin
              reason_next[i] = RSN_NONE;
              wait_next[i]   = '0;
              state_next[i]  = SLOT_READY;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Slot state is the only table field that needs a reset: fields of an
  // unused slot are never observed and are all rewritten by a spawn.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl_state[i] <= SLOT_UNUSED;
      end
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl_state[i] <= state_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_reason[i] <= reason_next[i];
      tbl_pid[i]    <= pid_next[i];
      tbl_parent[i] <= parent_next[i];
      tbl_space[i]  <= space_next[i];
      tbl_wait[i]   <= wait_next[i];
      tbl_exit[i]   <= exit_next[i];
    end
  end

  // Result of the request being executed.
  status_t           r_status;
  logic [31:0]       r_pid, r_space;
  logic signed [31:0] r_exit;
  logic [CW-1:0]     r_woken;
  logic              r_more;

  always_comb begin
    r_status = ST_ERROR;
    r_pid    = '0;
    r_space  = '0;
    r_exit   = '0;
    r_woken  = '0;
    r_more   = 1'b0;
    unique case (q_req)
      REQ_SPAWN: begin
        if (p_ffound) begin
          r_status = ST_OK;
          r_pid    = next_pid;
        end
      end
      REQ_WAIT: begin
        if (wait_ok) begin
          if (t_st == SLOT_ZOMBIE) begin
            r_status = ST_OK;
            r_exit   = tbl_exit[p_tidx];
          end else begin
            r_status = ST_PENDING;
          end
        end
      end
      REQ_KILL: begin
        if (kill_ok) r_status = ST_OK;
      end
      REQ_EXIT: begin
        if (p_tfound) begin
          if (t_st == SLOT_ZOMBIE) begin
            r_status = ST_OK;
            r_exit   = tbl_exit[p_tidx];
          end else begin
            r_status = ST_PENDING;
          end
        end
      end
      REQ_WAKE: begin
        r_status = ST_OK;
        r_woken  = p_woken;
      end
      REQ_DISPATCH: begin
        if (disp_ok) begin
          if (p_rfound) begin
            r_status = ST_OK;
            r_pid    = tbl_pid[p_ridx];
            r_space  = tbl_space[p_ridx];
          end else begin
            r_status = ST_NONE_READY;
          end
        end
      end
      REQ_REPORT: begin
        if (rep_ok) begin
          r_status = ST_OK;
          r_more   = (q_outcome != RUN_YIELDED);
        end
      end
      default: begin
      end
    endcase
  end

  // Scheduler registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_pid     <= 32'd1;
      rr_index     <= '0;
      running_pid  <= '0;
      running_slot <= '0;
    end else if (cmd.exec) begin
      if ((q_req == REQ_SPAWN) && p_ffound) begin
        next_pid <= next_pid + 32'd1;
      end
      if ((q_req == REQ_DISPATCH) && disp_ok && p_rfound) begin
        running_pid  <= tbl_pid[p_ridx];
        running_slot <= p_ridx;
        rr_index     <= (p_ridx == LAST) ? '0 : p_ridx + IW'(1);
      end
      if ((q_req == REQ_REPORT) && rep_ok) begin
        running_pid <= '0;
      end
    end
  end

  // Output register: one result beat per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= r_status;
      result_pid   <= r_pid;
      result_space <= r_space;
      result_exit  <= r_exit;
      woken_count  <= 5'(r_woken);
      more_work    <= r_more;
    end
  end

  assign sts.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

// ----- tb/pts_checker.sv -----
// Checker for the process table scheduler: watches both channels, keeps its own copy
// of the task table, predicts each result beat and compares it field by field.
// Depends on pts_pkg for the request, slot, reason, status and outcome codes.
`default_nettype none

module pts_checker
  import pts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] parent_id,
  input  wire logic        use_current_parent,
  input  wire logic [31:0] caller_id,
  input  wire logic [31:0] target_id,
  input  wire logic [31:0] space_id,
  input  wire logic [31:0] exit_code,
  input  wire logic [1:0]  run_outcome,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  status,
  input  wire logic [31:0] result_pid,
  input  wire logic [31:0] result_space,
  input  wire logic [31:0] result_exit,
  input  wire logic [4:0]  woken_count,
  input  wire logic        more_work,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = SLOT_COUNT_DEF;

  typedef struct packed {
    status_t     st;
    logic [31:0] pid;
    logic [31:0] spc;
    logic [31:0] ex;
    logic [4:0]  woken;
    logic        more;
  } sched_result_t;

  // Shadow of the task table.
  slot_state_t tbl_state [NSLOT];
  reason_t     tbl_reason[NSLOT];
  logic [31:0] tbl_pid   [NSLOT];
  logic [31:0] tbl_parent[NSLOT];
  logic [31:0] tbl_space [NSLOT];
  logic [31:0] tbl_waitf [NSLOT];
  logic [31:0] tbl_exit  [NSLOT];
  logic [31:0] pid_next;
  logic [3:0]  rr_ptr;
  logic [31:0] cur_pid;
  logic [3:0]  cur_slot;

  sched_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic void clear_entry(int i);
    tbl_state[i]  = SLOT_UNUSED;
    tbl_reason[i] = RSN_NONE;
    tbl_pid[i]    = '0;
    tbl_parent[i] = '0;
    tbl_space[i]  = '0;
    tbl_waitf[i]  = '0;
    tbl_exit[i]   = '0;
  endfunction

  // Lowest used slot holding the pid; pid 0 never matches.
  function automatic int find_pid(logic [31:0] pid);
    if (pid == 0) return -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_state[i] != SLOT_UNUSED && tbl_pid[i] == pid) return i;
    end
    return -1;
  endfunction

  // Turn a slot into a zombie and release everyone waiting on it.
  function automatic void to_zombie(int s, logic [31:0] code);
    logic [31:0] pid;
    pid = tbl_pid[s];
    tbl_exit[s]   = code;
    tbl_reason[s] = RSN_NONE;
    tbl_waitf[s]  = '0;
    tbl_state[s]  = SLOT_ZOMBIE;
    if (pid != 0) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tbl_state[i] == SLOT_BLOCKED && tbl_reason[i] == RSN_WAIT &&
            tbl_waitf[i] == pid) begin
          tbl_reason[i] = RSN_NONE;
          tbl_waitf[i]  = '0;
          tbl_state[i]  = SLOT_READY;
        end
      end
    end
  endfunction

  // Apply one request to the shadow table and return the result it yields.
  function automatic sched_result_t schedule_request();
    sched_result_t r;
    int s;
    int c;
    int k;
    r = '0;
    r.st = ST_ERROR;
    case (req_type)
      REQ_SPAWN: begin
        s = -1;
        for (int i = NSLOT - 1; i >= 0; i--) begin
          if (tbl_state[i] == SLOT_UNUSED) s = i;
        end
        if (s >= 0) begin
          r.pid = pid_next;
          pid_next = pid_next + 32'd1;
          tbl_pid[s]    = r.pid;
          tbl_parent[s] = use_current_parent ? cur_pid : parent_id;
          tbl_space[s]  = space_id;
          tbl_state[s]  = SLOT_READY;
          tbl_reason[s] = RSN_NONE;
          tbl_waitf[s]  = '0;
          tbl_exit[s]   = '0;
          r.st = ST_OK;
        end
      end
      REQ_WAIT: begin
        c = find_pid(caller_id);
        s = find_pid(target_id);
        if (c >= 0 && target_id != 0 && caller_id != target_id && s >= 0 &&
            tbl_parent[s] == caller_id) begin
          if (tbl_state[s] == SLOT_ZOMBIE) begin
            r.ex = tbl_exit[s];
            clear_entry(s);
            tbl_reason[c] = RSN_NONE;
            tbl_waitf[c]  = '0;
            r.st = ST_OK;
          end else begin
            tbl_reason[c] = RSN_WAIT;
            tbl_waitf[c]  = target_id;
            r.st = ST_PENDING;
          end
        end
      end
      REQ_KILL: begin
        s = find_pid(target_id);
        if (s >= 0 && target_id != cur_pid &&
            !(cur_pid != 0 && tbl_parent[s] != cur_pid)) begin
          if (tbl_state[s] != SLOT_ZOMBIE) to_zombie(s, exit_code);
          r.st = ST_OK;
        end
      end
      REQ_EXIT: begin
        s = find_pid(target_id);
        if (s >= 0) begin
          if (tbl_state[s] != SLOT_ZOMBIE) begin
            r.st = ST_PENDING;
          end else begin
            r.ex = tbl_exit[s];
            r.st = ST_OK;
          end
        end
      end
      REQ_WAKE: begin
        r.st = ST_OK;
        if (space_id != 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (tbl_space[i] == space_id && tbl_state[i] == SLOT_BLOCKED &&
                tbl_reason[i] == RSN_IPC) begin
              tbl_reason[i] = RSN_NONE;
              tbl_state[i]  = SLOT_READY;
              r.woken = r.woken + 5'd1;
            end
          end
        end
      end
      REQ_DISPATCH: begin
        if (cur_pid == 0) begin
          r.st = ST_NONE_READY;
          for (int i = 0; i < NSLOT; i++) begin
            k = (int'(rr_ptr) + i) % NSLOT;
            if (r.st == ST_NONE_READY && tbl_state[k] == SLOT_READY) begin
              tbl_state[k] = SLOT_RUNNING;
              cur_pid  = tbl_pid[k];
              cur_slot = k[3:0];
              rr_ptr   = 4'(k + 1);
              r.pid = tbl_pid[k];
              r.spc = tbl_space[k];
              r.st  = ST_OK;
            end
          end
        end
      end
      REQ_REPORT: begin
        if (cur_pid != 0) begin
          s = int'(cur_slot);
          cur_pid = '0;
          if (run_outcome == RUN_EXITED) begin
            to_zombie(s, tbl_exit[s]);
          end else if (run_outcome == RUN_BLOCKED) begin
            tbl_state[s] = SLOT_BLOCKED;
            if (tbl_reason[s] == RSN_NONE) tbl_reason[s] = RSN_IPC;
          end else begin
            tbl_state[s]  = SLOT_READY;
            tbl_reason[s] = RSN_NONE;
            tbl_waitf[s]  = '0;
          end
          r.more = (run_outcome != RUN_YIELDED);
          r.st = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Predict on every accepted request beat, compare every accepted result beat.
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) clear_entry(i);
      pid_next = 32'd1;
      rr_ptr   = '0;
      cur_pid  = '0;
      cur_slot = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(schedule_request());
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status != exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, status);
            fail_count++;
          end
          if (result_pid != exp_r.pid) begin
            $error("result_pid: expected %0d, got %0d", exp_r.pid, result_pid);
            fail_count++;
          end
          if (result_space != exp_r.spc) begin
            $error("result_space: expected %0d, got %0d", exp_r.spc, result_space);
            fail_count++;
          end
          if (result_exit != exp_r.ex) begin
            $error("result_exit: expected %0d, got %0d",
                   $signed(exp_r.ex), $signed(result_exit));
            fail_count++;
          end
          if (woken_count != exp_r.woken) begin
            $error("woken_count: expected %0d, got %0d", exp_r.woken, woken_count);
            fail_count++;
          end
          if (more_work != exp_r.more) begin
            $error("more_work: expected %0d, got %0d", exp_r.more, more_work);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Top of the process table scheduler testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on pts_pkg, the block and pts_checker.
`default_nettype none

module tb_top
  import pts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [31:0] parent_id = '0;
  logic        use_current_parent = 1'b0;
  logic [31:0] caller_id = '0;
  logic [31:0] target_id = '0;
  logic [31:0] space_id = '0;
  logic [31:0] exit_code = '0;
  logic [1:0]  run_outcome = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] result_pid;
  logic [31:0] result_space;
  logic [31:0] result_exit;
  logic [4:0]  woken_count;
  logic        more_work;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int spawns_sent = 0;
  int quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 5000;

  always #2 clk = ~clk;

  process_table_round_robin_scheduler u_dut (.*);

  pts_checker u_chk (.*);

  // Result side back-pressure.
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: give up after a long stretch with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one request beat and hold it until it is taken.
  task automatic send_req(req_t rq, logic [31:0] par, logic cur, logic [31:0] caller,
                          logic [31:0] target, logic [31:0] spc, logic [31:0] code,
                          logic [1:0] outc);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    req_type           <= rq;
    parent_id          <= par;
    use_current_parent <= cur;
    caller_id          <= caller;
    target_id          <= target;
    space_id           <= spc;
    exit_code          <= code;
    run_outcome        <= outc;
    if (rq == REQ_SPAWN) spawns_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A pid that is probably live, with an occasional zero or wild value.
  function automatic logic [31:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 9) return $urandom;
    return $urandom_range(spawns_sent + 1, (spawns_sent > 20) ? spawns_sent - 20 : 1);
  endfunction

  function automatic logic [31:0] pick_space();
    return ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 3));
  endfunction

  // Random mix weighted towards spawn, dispatch and report so that the table churns.
  task automatic send_random();
    int r;
    req_t rq;
    logic [2:0] raw;
    logic [31:0] cl;
    r = $urandom_range(0, 99);
    if (r < 22) rq = REQ_SPAWN;
    else if (r < 42) rq = REQ_DISPATCH;
    else if (r < 58) rq = REQ_REPORT;
    else if (r < 70) rq = REQ_KILL;
    else if (r < 82) rq = REQ_WAIT;
    else if (r < 90) rq = REQ_EXIT;
    else rq = REQ_WAKE;
    raw = rq;
    if ($urandom_range(0, 49) == 0) raw = 3'b111;
    cl = pick_pid();
    send_req(req_t'(raw), ($urandom_range(0, 3) == 0) ? 32'($urandom) : pick_pid(),
             1'($urandom_range(0, 1)), cl, ($urandom_range(0, 19) == 0) ? cl : pick_pid(),
             pick_space(), $urandom, 2'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field extremes, every request, and the error paths.
    idle_pct = 10;
    stall_pct = 30;
    send_req(REQ_REPORT, 0, 0, 0, 0, 0, 0, RUN_EXITED);       // report with none running
    send_req(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 0);              // nothing ready
    send_req(REQ_SPAWN, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
    send_req(REQ_SPAWN, 0, 1, 0, 0, 0, 0, 0);
    send_req(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 0);              // dispatch while running
    send_req(REQ_SPAWN, 0, 1, 0, 0, 32'd5, 0, 0);             // parent is the running pid
    send_req(REQ_REPORT, 0, 0, 0, 0, 0, 0, RUN_BLOCKED);
    send_req(REQ_WAKE, 0, 0, 0, 0, 32'd0, 0, 0);              // context zero wakes nothing
    send_req(REQ_WAKE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
    send_req(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_REPORT, 0, 0, 0, 0, 0, 0, RUN_YIELDED);
    send_req(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_KILL, 0, 0, 0, 32'd3, 0, 32'h8000_0000, 0);  // running pid targets itself: refused
    send_req(REQ_REPORT, 0, 0, 0, 0, 0, 0, RUN_OTHER);
    send_req(REQ_WAIT, 0, 0, 32'd1, 32'd1, 0, 0, 0);          // wait on itself
    send_req(REQ_WAIT, 0, 0, 32'd2, 32'd3, 0, 0, 0);          // caller is not the target's parent: refused
    send_req(REQ_KILL, 0, 0, 0, 32'd1, 0, 32'h7FFF_FFFF, 0);
    send_req(REQ_KILL, 0, 0, 0, 32'd1, 0, 32'd9, 0);          // already a zombie
    send_req(REQ_EXIT, 0, 0, 0, 32'd1, 0, 0, 0);
    send_req(REQ_EXIT, 0, 0, 0, 32'd2, 0, 0, 0);              // not yet exited
    send_req(REQ_EXIT, 0, 0, 0, 32'd0, 0, 0, 0);
    send_req(req_t'(3'b111), 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11);
    go_idle();
    drain();

    // Random part in three idling phases, with one full drain mid-way.
    idle_pct = 16;
    stall_pct = 74;
    repeat (130) send_random();
    go_idle();
    drain();
    idle_pct = 74;
    stall_pct = 16;
    repeat (130) send_random();
    idle_pct = 0;
    stall_pct = 0;
    repeat (140) send_random();
    go_idle();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/pts_pkg.sv
src/pts_ctrl.sv
src/pts_dp.sv
src/process_table_round_robin_scheduler.sv
tb/pts_checker.sv
tb/tb_top.sv
